// File: hdl/wrsd_pkg.sv
// Shared constants and types of the window range steady detector.
package wrsd_pkg;

  localparam int WINDOW_LEN_DEF  = 30;
  localparam int SAMPLE_BITS_DEF = 10;
  localparam int FIELD_BITS      = 10;

  localparam logic [FIELD_BITS-1:0] THRESH_RESET = 10'd5;

  typedef struct packed {
    logic shift;
    logic load_new;
  } chain_ctl_t;

endpackage

// File: hdl/wrsd_in_if.sv
// Input channel interface carrying one sensor sample per transaction.
interface wrsd_in_if;
  import wrsd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// File: hdl/wrsd_out_if.sv
// Result channel interface carrying the window range and steady flag.
interface wrsd_out_if;
  import wrsd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  steady;
  logic [FIELD_BITS-1:0] window_range;

  modport source (output valid, output steady, output window_range, input ready);
  modport sink (input valid, input steady, input window_range, output ready);
endinterface

// File: hdl/wrsd_cell.sv
// One window cell holding a single sample and passing it to its neighbor.
module wrsd_cell #(
  parameter int SAMPLE_BITS = wrsd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   shift,
  input  logic [SAMPLE_BITS-1:0] din,
  output logic [SAMPLE_BITS-1:0] dout
);

  logic [SAMPLE_BITS-1:0] sample_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_r <= '0;
    end else if (shift) begin
      sample_r <= din;
    end
  end

  assign dout = sample_r;

endmodule

// File: hdl/wrsd_scan.sv
// Sequencer that rotates the cell chain past one min/max unit and registers the result.
module wrsd_scan #(
  parameter int WINDOW_LEN  = wrsd_pkg::WINDOW_LEN_DEF,
  parameter int SAMPLE_BITS = wrsd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  wrsd_in_if.sink                         in_ch,
  wrsd_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [wrsd_pkg::FIELD_BITS-1:0] cfg_wdata,
  input  logic [SAMPLE_BITS-1:0]          head_sample,
  output logic [SAMPLE_BITS-1:0]          fresh_sample,
  output wrsd_pkg::chain_ctl_t            chain_ctl
);
  import wrsd_pkg::*;

  localparam int CNT_BITS = $clog2(WINDOW_LEN);
  localparam int CMP_BITS = (SAMPLE_BITS > FIELD_BITS) ? SAMPLE_BITS : FIELD_BITS;
  localparam logic [FIELD_BITS-1:0] FIELD_MAX = '1;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

  state_t                 state_r, state_nxt;
  logic [CNT_BITS-1:0]    cnt_r, cnt_nxt;
  logic [SAMPLE_BITS-1:0] hi_r, hi_nxt;
  logic [SAMPLE_BITS-1:0] lo_r, lo_nxt;
  logic [FIELD_BITS-1:0]  thresh_r;
  logic                   out_valid_r, out_valid_nxt;
  logic                   steady_r, steady_nxt;
  logic [FIELD_BITS-1:0]  range_r, range_nxt;

  logic [CMP_BITS-1:0]    sample_ext;
  logic [SAMPLE_BITS-1:0] span;
  logic [CMP_BITS-1:0]    span_ext;
  logic                   accept;

  assign sample_ext   = CMP_BITS'(in_ch.sample);
  assign fresh_sample = sample_ext[SAMPLE_BITS-1:0];
  assign span         = hi_r - lo_r;
  assign span_ext     = CMP_BITS'(span);

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign accept              = in_ch.valid && in_ch.ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.steady       = steady_r;
  assign out_ch.window_range = range_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    hi_nxt        = hi_r;
    lo_nxt        = lo_r;
    out_valid_nxt = out_valid_r;
    steady_nxt    = steady_r;
    range_nxt     = range_r;
    chain_ctl     = '0;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          chain_ctl.shift    = 1'b1;
          chain_ctl.load_new = 1'b1;
          cnt_nxt            = '0;
          state_nxt          = ST_SCAN;
        end
      end
      ST_SCAN: begin
        chain_ctl.shift = 1'b1;
        if (cnt_r == '0) begin
          hi_nxt = head_sample;
          lo_nxt = head_sample;
        end else begin
          if (head_sample > hi_r) begin
            hi_nxt = head_sample;
          end
          if (head_sample < lo_r) begin
            lo_nxt = head_sample;
          end
        end
        if (cnt_r == CNT_BITS'(WINDOW_LEN - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          steady_nxt    = (span_ext < CMP_BITS'(thresh_r));
          if (span_ext > CMP_BITS'(FIELD_MAX)) begin
            range_nxt = FIELD_MAX;
          end else begin
            range_nxt = span_ext[FIELD_BITS-1:0];
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      hi_r        <= '0;
      lo_r        <= '0;
      thresh_r    <= THRESH_RESET;
      out_valid_r <= 1'b0;
      steady_r    <= 1'b0;
      range_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      hi_r        <= hi_nxt;
      lo_r        <= lo_nxt;
      out_valid_r <= out_valid_nxt;
      steady_r    <= steady_nxt;
      range_r     <= range_nxt;
      if (cfg_we) begin
        thresh_r <= cfg_wdata;
      end
    end
  end

endmodule

// File: hdl/window_range_steady_detector.sv
// Top level: sliding window of sample cells with a rotating min/max scan.
// The input transaction starts a scan state that rotates the chain, then a done state loads the result register.
// A new transaction is taken only in the idle state, after the whole cell chain has rotated once
// past the single min/max unit; a result stalled at the output can hold the block in its done state.
// A pending result waits in the output register while the next sample is taken.
// Synchronous reset clears every window cell to zero and sets the threshold to 5.
module window_range_steady_detector #(
  parameter int WINDOW_LEN  = wrsd_pkg::WINDOW_LEN_DEF,
  parameter int SAMPLE_BITS = wrsd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  wrsd_in_if.sink                         in_ch,
  wrsd_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [wrsd_pkg::FIELD_BITS-1:0] cfg_wdata
);
  import wrsd_pkg::*;

  chain_ctl_t             chain_ctl;
  logic [SAMPLE_BITS-1:0] fresh_sample;
  logic [SAMPLE_BITS-1:0] tail_in;
  logic [SAMPLE_BITS-1:0] tap [WINDOW_LEN];

  assign tail_in = chain_ctl.load_new ? fresh_sample : tap[0];

  for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
    logic [SAMPLE_BITS-1:0] din;
    if (i == WINDOW_LEN - 1) begin : g_tail
      assign din = tail_in;
    end else begin : g_body
      assign din = tap[i+1];
    end
    wrsd_cell #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .shift(chain_ctl.shift),
      .din  (din),
      .dout (tap[i])
    );
  end

  wrsd_scan #(
    .WINDOW_LEN (WINDOW_LEN),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .head_sample (tap[0]),
    .fresh_sample(fresh_sample),
    .chain_ctl   (chain_ctl)
  );

endmodule

// File: hdl/wrsd_checker.sv
// Port-level checker for the window range steady detector and its bind.
module wrsd_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            out_steady,
  input logic [wrsd_pkg::FIELD_BITS-1:0] out_window_range,
  input logic                            cfg_we,
  input logic [wrsd_pkg::FIELD_BITS-1:0] cfg_wdata
);
  import wrsd_pkg::*;

  logic [FIELD_BITS-1:0] thresh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
    end else if (cfg_we) begin
      thresh_r <= cfg_wdata;
    end
  end

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a transaction is being scanned");

  a_steady_matches_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_steady == (out_window_range < thresh_r)))
    else $error("steady flag disagrees with range and threshold");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_steady)
      && $stable(out_window_range))
    else $error("stalled result changed");

endmodule

bind window_range_steady_detector wrsd_checker u_wrsd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_steady      (out_ch.steady),
  .out_window_range(out_ch.window_range),
  .cfg_we          (cfg_we),
  .cfg_wdata       (cfg_wdata)
);

// File: sim/window_range_steady_detector_tb.sv
// Testbench for the sliding-window range detector, checked against a built-in window predictor.
`timescale 1ns / 1ps

module window_range_steady_detector_tb;
  import wrsd_pkg::*;

  localparam int FIELD_MAX = (1 << FIELD_BITS) - 1;
  localparam int GAP_MAX = 18;
  localparam int LONG_HOLD = 400;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 204;

  typedef struct packed {
    logic                  steady;
    logic [FIELD_BITS-1:0] window_range;
  } range_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [FIELD_BITS-1:0] cfg_wdata;

  wrsd_in_if in_ch ();
  wrsd_out_if out_ch ();

  window_range_steady_detector u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  logic [SAMPLE_BITS_DEF-1:0] sample_history [WINDOW_LEN_DEF] = '{default: '0};
  logic [FIELD_BITS-1:0] steady_limit = THRESH_RESET;

  logic [FIELD_BITS-1:0] pending_samples [$];
  range_result_t expected_ranges [$];

  logic in_fire;
  logic out_fire;
  int in_wait;
  int out_wait;
  int out_hold;
  bit idle_off;
  bit long_hold_armed;
  bit long_hold_done;

  int samples_taken;
  int results_checked;
  int steady_results;
  int mismatch_count;
  int settings_used;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic int draw_gap(input bit no_idle);
    return no_idle ? 0 : $urandom_range(0, GAP_MAX);
  endfunction

  function automatic range_result_t shift_and_measure(input logic [FIELD_BITS-1:0] sample);
    logic [SAMPLE_BITS_DEF-1:0] hi;
    logic [SAMPLE_BITS_DEF-1:0] lo;
    int span;
    range_result_t res;
    for (int i = 0; i < WINDOW_LEN_DEF - 1; i++) begin
      sample_history[i] = sample_history[i + 1];
    end
    sample_history[WINDOW_LEN_DEF - 1] = sample[SAMPLE_BITS_DEF-1:0];
    hi = sample_history[0];
    lo = sample_history[0];
    for (int i = 1; i < WINDOW_LEN_DEF; i++) begin
      if (sample_history[i] > hi) hi = sample_history[i];
      if (sample_history[i] < lo) lo = sample_history[i];
    end
    span = int'(hi) - int'(lo);
    res.steady = (span < int'(steady_limit));
    res.window_range = (span > FIELD_MAX) ? FIELD_BITS'(FIELD_MAX) : span[FIELD_BITS-1:0];
    return res;
  endfunction

  // Input side: predict on each accepted transaction, drive at the falling edge.
  always @(posedge clk) begin
    in_fire <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      expected_ranges.push_back(shift_and_measure(in_ch.sample));
      samples_taken++;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.sample <= '0;
      in_wait <= 0;
    end else if (!in_ch.valid || in_fire) begin
      if (in_wait > 0) begin
        in_ch.valid <= 1'b0;
        in_wait <= in_wait - 1;
      end else if (pending_samples.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.sample <= pending_samples.pop_front();
        in_wait <= draw_gap(idle_off);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Output side: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    range_result_t want;
    out_fire <= rst_n && out_ch.valid && out_ch.ready;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_ranges.size() == 0) begin
        $error("unexpected result: steady=%0d window_range=%0d",
               out_ch.steady, out_ch.window_range);
        mismatch_count++;
      end else begin
        want = expected_ranges.pop_front();
        results_checked++;
        if (want.steady) steady_results++;
        if (out_ch.steady !== want.steady) begin
          $error("steady: expected %0d, got %0d", want.steady, out_ch.steady);
          mismatch_count++;
        end
        if (out_ch.window_range !== want.window_range) begin
          $error("window_range: expected %0d, got %0d",
                 want.window_range, out_ch.window_range);
          mismatch_count++;
        end
      end
    end
  end

  always @(negedge clk) begin
    int gap;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_wait <= 0;
      out_hold <= 0;
    end else if (long_hold_armed && !long_hold_done) begin
      out_ch.ready <= 1'b0;
      out_hold <= LONG_HOLD;
      long_hold_done <= 1'b1;
    end else if (out_hold > 0) begin
      out_ch.ready <= 1'b0;
      out_hold <= out_hold - 1;
    end else if (out_fire) begin
      gap = draw_gap(idle_off);
      out_ch.ready <= (gap == 0);
      out_wait <= (gap > 0) ? gap - 1 : 0;
    end else if (!out_ch.ready) begin
      if (out_wait > 0) begin
        out_wait <= out_wait - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic write_threshold(input logic [FIELD_BITS-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    steady_limit = value;
    settings_used++;
  endtask

  task automatic drain();
    while (pending_samples.size() != 0 || in_ch.valid || expected_ranges.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Mostly runs of samples within a narrow band near the threshold, with noise and spikes.
  task automatic queue_phase(input int n_items);
    int left;
    int run;
    int lo;
    int hi;
    int spike_at;
    logic [FIELD_BITS-1:0] val;
    left = n_items;
    while (left > 0) begin
      run = $urandom_range(10, 60);
      if (run > left) run = left;
      if ($urandom_range(0, 9) < 2) begin
        lo = 0;
        hi = FIELD_MAX;
      end else begin
        lo = $urandom_range(0, FIELD_MAX);
        hi = lo + $urandom_range(0, int'(steady_limit) + 1);
        if (hi > FIELD_MAX) hi = FIELD_MAX;
      end
      spike_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, run - 1) : -1;
      for (int k = 0; k < run; k++) begin
        val = (k == spike_at) ? FIELD_BITS'($urandom_range(0, FIELD_MAX))
                              : FIELD_BITS'($urandom_range(lo, hi));
        pending_samples.push_back(val);
      end
      left -= run;
    end
  endtask

  initial begin
    logic [FIELD_BITS-1:0] directed [$];
    int fixed_limits [5];
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    out_ch.ready = 1'b0;
    fixed_limits = '{0, FIELD_MAX, 1, int'(THRESH_RESET), 64};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Zero-filled window, range just below and at the reset threshold, then the extremes.
    directed = '{10'd0, 10'd4, 10'd5, 10'd3, 10'd1023, 10'd0, 10'd1, 10'd1022, 10'd512,
                 10'd511, 10'd341, 10'd682, 10'd1023, 10'd1023, 10'd0, 10'd0, 10'd256,
                 10'd768, 10'd85, 10'd938};
    foreach (directed[i]) pending_samples.push_back(directed[i]);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      write_threshold(p < 5 ? FIELD_BITS'(fixed_limits[p])
                            : FIELD_BITS'($urandom_range(0, FIELD_MAX)));
      idle_off = (p == 4);
      if (p == 2) long_hold_armed = 1'b1;
      queue_phase(PHASE_ITEMS);
      drain();
    end

    repeat (WINDOW_LEN_DEF + 8) @(posedge clk);
    $display("Run covered %0d sample transactions under %0d threshold settings.",
             samples_taken, settings_used + 1);
    $display("Checked %0d results, %0d of them steady, with %0d mismatches.",
             results_checked, steady_results, mismatch_count);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding.", expected_ranges.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
